// ===== rtl/core/adt_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and the crc-8 byte step for the directory table block
// no dependencies
package adt_pkg;

	localparam int FIRST_ENTRIES  = 15;
	localparam int SECOND_ENTRIES = 23;

	localparam int FIRST_AW  = (FIRST_ENTRIES > 1) ? $clog2(FIRST_ENTRIES) : 1;
	localparam int SECOND_AW = (SECOND_ENTRIES > 1) ? $clog2(SECOND_ENTRIES) : 1;
	localparam int IDX_W     = (FIRST_AW > SECOND_AW) ? FIRST_AW : SECOND_AW;

	localparam logic [7:0] CRC_SEED     = 8'hC7;
	localparam logic [7:0] CRC_POLY     = 8'h1D;
	localparam logic [7:0] LIMIT_V2     = 8'h27;
	localparam logic [7:0] LIMIT_V1     = 8'h0F;
	localparam logic [7:0] SPLIT_SECTOR = 8'h10;

	localparam logic [1:0] MODE_READ  = 2'd0;
	localparam logic [1:0] MODE_WRITE = 2'd1;
	localparam logic [1:0] MODE_PUB   = 2'd2;
	localparam logic [1:0] MODE_CRC   = 2'd3;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_BAD_SECTOR = 2'd1;
	localparam logic [1:0] STATUS_NEED_V2   = 2'd2;
	localparam logic [1:0] STATUS_PUB_RANGE = 2'd3;

	localparam logic [1:0] VERSION_1 = 2'd1;
	localparam logic [1:0] VERSION_2 = 2'd2;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] sector;
		logic [7:0] cluster_in;
		logic [7:0] app_code_in;
		logic [7:0] publisher_sector;
		logic       region;
		logic [7:0] expected_crc;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] cluster_out;
		logic [7:0] app_code_out;
		logic [7:0] crc_value;
		logic       crc_match;
	} rsp_t;

	typedef struct packed {
		logic init;
		logic step;
	} crc_ctl_t;

	// one byte through the msb-first crc-8
	function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== rtl/core/adt_ram.sv =====
`timescale 1ns / 1ps
// directory table storage: one write port, one registered read port, per-entry valid bits
// entries that are not valid read as zero; clr drops all valid bits at once
module adt_ram #(
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          clr,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [15:0]   wr_data,
	input  logic [AW-1:0] rd_addr,
	output logic [15:0]   rd_data
);

	logic [15:0]      mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [15:0]      rd_q;
	logic             rd_hit;

	assign rd_hit  = (int'(rd_addr) < DEPTH) && valid_q[rd_addr];
	assign rd_data = rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (clr) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= rd_hit ? mem[rd_addr] : 16'h0000;
	end

endmodule

// ===== rtl/core/adt_crc.sv =====
`timescale 1ns / 1ps
// shared crc-8 unit: one byte per cycle, while init or step is set, into the running remainder
// depends on adt_pkg for the byte step and the control struct
module adt_crc (
	input  logic              clk,
	input  logic              arst_n,
	input  adt_pkg::crc_ctl_t ctl,
	input  logic [7:0]        data,
	output logic [7:0]        crc
);
	import adt_pkg::*;

	logic [7:0] crc_q;
	logic [7:0] base;

	assign base = ctl.init ? CRC_SEED : crc_q;
	assign crc  = crc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= '0;
		end else if (ctl.init || ctl.step) begin
			crc_q <= crc_byte(base, data);
		end
	end

endmodule

// ===== rtl/core/application_directory_table_crc8.sv =====
`timescale 1ns / 1ps
// Sector directory with two tables, a publisher byte and a crc-8 check. Each request
// takes one transfer in and gives one transfer out. Entry read, entry write and
// publisher set pass from accept through the op and finish states. A crc request walks
// the info byte and then two bytes per entry through the single crc byte unit, one byte
// per cycle, before the finish state. The request side is not ready until the current
// request has handed its result to the output register, which holds it until taken.
// Depends on adt_pkg, adt_ram and adt_crc.
module application_directory_table_crc8 (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wen,
	input  logic [1:0]    cfg_wdata,
	input  logic          req_valid,
	output logic          req_ready,
	input  adt_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output adt_pkg::rsp_t rsp
);
	import adt_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_OP,
		S_INFO,
		S_APP,
		S_CL,
		S_FIN
	} state_t;

	state_t           state_q;
	logic [1:0]       version_q;
	logic [5:0]       pub_q;
	logic [1:0]       status_q;
	logic             second_q;
	logic             last_q;
	logic [IDX_W-1:0] idx_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;
	req_t             req_q;

	logic             accept;
	logic [1:0]       dec_status;
	logic             dec_second;
	logic [IDX_W-1:0] dec_idx;
	logic [7:0]       sec_m1;
	logic [7:0]       sec_m17;
	logic [7:0]       limit;
	logic             clr_second;
	logic             wr_ok;
	logic [15:0]      rd_first;
	logic [15:0]      rd_second;
	logic [15:0]      rd_sel;
	logic [IDX_W-1:0] idx_end;
	logic             out_free;
	crc_ctl_t         crc_ctl;
	logic [7:0]       crc_data;
	logic [7:0]       crc_cur;
	rsp_t             rsp_next;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign out_free  = !rsp_valid_q || rsp_ready;

	assign sec_m1  = req.sector - 8'd1;
	assign sec_m17 = req.sector - (SPLIT_SECTOR + 8'd1);
	assign limit   = (version_q == VERSION_2) ? LIMIT_V2 : LIMIT_V1;

	// request decode at the accepting edge
	always_comb begin
		dec_status = STATUS_OK;
		dec_second = 1'b0;
		dec_idx    = '0;
		unique case (req.mode)
			MODE_READ, MODE_WRITE: begin
				if (req.sector == 8'd0 || req.sector == SPLIT_SECTOR) begin
					dec_status = STATUS_BAD_SECTOR;
				end else if (req.sector < SPLIT_SECTOR) begin
					if (sec_m1 >= 8'(FIRST_ENTRIES)) begin
						dec_status = STATUS_BAD_SECTOR;
					end else begin
						dec_idx = IDX_W'(sec_m1);
					end
				end else if (sec_m17 >= 8'(SECOND_ENTRIES)) begin
					dec_status = STATUS_BAD_SECTOR;
				end else if (version_q != VERSION_2) begin
					dec_status = STATUS_NEED_V2;
				end else begin
					dec_second = 1'b1;
					dec_idx    = IDX_W'(sec_m17);
				end
			end
			MODE_PUB: begin
				if (req.publisher_sector > limit) begin
					dec_status = STATUS_PUB_RANGE;
				end
			end
			MODE_CRC: begin
				dec_second = req.region;
			end
			default: begin
				dec_status = STATUS_OK;
			end
		endcase
	end

	assign clr_second = cfg_wen && (cfg_wdata == VERSION_2) && (version_q == VERSION_1);
	assign wr_ok      = (state_q == S_OP) && (req_q.mode == MODE_WRITE) &&
	                    (status_q == STATUS_OK);

	adt_ram #(.DEPTH(FIRST_ENTRIES)) u_first (
		.clk     (clk),
		.arst_n  (arst_n),
		.clr     (1'b0),
		.wr_en   (wr_ok && !second_q),
		.wr_addr (idx_q[FIRST_AW-1:0]),
		.wr_data ({req_q.cluster_in, req_q.app_code_in}),
		.rd_addr (idx_q[FIRST_AW-1:0]),
		.rd_data (rd_first)
	);

	adt_ram #(.DEPTH(SECOND_ENTRIES)) u_second (
		.clk     (clk),
		.arst_n  (arst_n),
		.clr     (clr_second),
		.wr_en   (wr_ok && second_q),
		.wr_addr (idx_q[SECOND_AW-1:0]),
		.wr_data ({req_q.cluster_in, req_q.app_code_in}),
		.rd_addr (idx_q[SECOND_AW-1:0]),
		.rd_data (rd_second)
	);

	assign rd_sel  = second_q ? rd_second : rd_first;
	assign idx_end = second_q ? IDX_W'(SECOND_ENTRIES - 1) : IDX_W'(FIRST_ENTRIES - 1);

	// byte feed for the crc unit
	always_comb begin
		crc_ctl.init = (state_q == S_INFO);
		crc_ctl.step = (state_q == S_APP) || (state_q == S_CL);
		unique case (state_q)
			S_INFO:  crc_data = second_q ? 8'h00 : {2'b00, pub_q};
			S_APP:   crc_data = rd_sel[7:0];
			S_CL:    crc_data = rd_sel[15:8];
			default: crc_data = 8'h00;
		endcase
	end

	adt_crc u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (crc_ctl),
		.data   (crc_data),
		.crc    (crc_cur)
	);

	always_comb begin
		rsp_next = '0;
		rsp_next.status = status_q;
		if (req_q.mode == MODE_READ && status_q == STATUS_OK) begin
			rsp_next.cluster_out  = rd_sel[15:8];
			rsp_next.app_code_out = rd_sel[7:0];
		end
		if (req_q.mode == MODE_CRC) begin
			rsp_next.crc_value = crc_cur;
			rsp_next.crc_match = (crc_cur == req_q.expected_crc);
		end
	end

	// request payload capture
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			version_q   <= VERSION_1;
			pub_q       <= '0;
			status_q    <= STATUS_OK;
			second_q    <= 1'b0;
			last_q      <= 1'b0;
			idx_q       <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (cfg_wen) begin
				version_q <= cfg_wdata;
			end
			if (rsp_valid_q && rsp_ready && state_q != S_FIN) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						status_q <= dec_status;
						second_q <= dec_second;
						idx_q    <= dec_idx;
						last_q   <= 1'b0;
						state_q  <= (req.mode == MODE_CRC) ? S_INFO : S_OP;
					end
				end
				S_OP: begin
					if (req_q.mode == MODE_PUB && status_q == STATUS_OK) begin
						pub_q <= req_q.publisher_sector[5:0];
					end
					state_q <= S_FIN;
				end
				S_INFO: begin
					state_q <= S_APP;
				end
				S_APP: begin
					if (idx_q == idx_end) begin
						last_q <= 1'b1;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
					state_q <= S_CL;
				end
				S_CL: begin
					state_q <= last_q ? S_FIN : S_APP;
				end
				S_FIN: begin
					if (out_free) begin
						rsp_q       <= rsp_next;
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// self-checking testbench for application_directory_table_crc8: directed table, then random
// phases under several directory versions, checked against an in-bench directory/crc model
// depends on adt_pkg and the application_directory_table_crc8 rtl
module testbench;
	import adt_pkg::*;

	localparam logic [1:0] VERSION_0 = 2'd0;
	localparam logic [1:0] VERSION_3 = 2'd3;
	localparam int STALL_LIMIT = 3000;
	localparam int PHASE_ITEMS = 203;
	localparam int SQUEEZE_AT = 300;
	localparam int SQUEEZE_CYCLES = 400;

	typedef struct packed {
		logic       set_ver;
		logic [1:0] ver;
		req_t       item;
		logic       typed;
		logic [1:0] status;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wen = 1'b0;
	logic [1:0] cfg_wdata = 2'd0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	// directory model
	logic [15:0] dir_first [FIRST_ENTRIES];
	logic [15:0] dir_second [SECOND_ENTRIES];
	logic [5:0] pub_code;
	logic [1:0] dir_ver;

	rsp_t result_q [$];
	plan_row_t plan [$];
	int outstanding = 0;
	int errors = 0;
	int send_calm = 0;

	always #5 clk = ~clk;

	application_directory_table_crc8 dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_wdata(cfg_wdata),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] data);
		logic [7:0] c;
		c = acc ^ data;
		repeat (8) begin
			c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

	function automatic logic [7:0] region_crc(input logic region);
		logic [7:0] acc;
		if (!region) begin
			acc = crc8_step(CRC_SEED, {2'b00, pub_code});
			for (int i = 0; i < FIRST_ENTRIES; i++) begin
				acc = crc8_step(acc, dir_first[i][7:0]);
				acc = crc8_step(acc, dir_first[i][15:8]);
			end
		end else begin
			acc = crc8_step(CRC_SEED, 8'h00);
			for (int i = 0; i < SECOND_ENTRIES; i++) begin
				acc = crc8_step(acc, dir_second[i][7:0]);
				acc = crc8_step(acc, dir_second[i][15:8]);
			end
		end
		return acc;
	endfunction

	function automatic rsp_t directory_predict(input req_t r);
		rsp_t o;
		logic [1:0] st;
		logic [15:0] entry;
		int slot;
		bit in_second;
		o = '0;
		st = STATUS_OK;
		slot = 0;
		in_second = 1'b0;
		case (r.mode)
			MODE_READ, MODE_WRITE: begin
				if (r.sector == 0 || r.sector == SPLIT_SECTOR) begin
					st = STATUS_BAD_SECTOR;
				end else if (r.sector < SPLIT_SECTOR) begin
					if (r.sector > FIRST_ENTRIES) st = STATUS_BAD_SECTOR;
					else slot = r.sector - 1;
				end else if (r.sector > SPLIT_SECTOR + SECOND_ENTRIES) begin
					st = STATUS_BAD_SECTOR;
				end else if (dir_ver != VERSION_2) begin
					st = STATUS_NEED_V2;
				end else begin
					in_second = 1'b1;
					slot = r.sector - SPLIT_SECTOR - 1;
				end
				if (st == STATUS_OK) begin
					if (r.mode == MODE_READ) begin
						if (in_second) entry = dir_second[slot];
						else entry = dir_first[slot];
						o.cluster_out = entry[15:8];
						o.app_code_out = entry[7:0];
					end else if (in_second) begin
						dir_second[slot] = {r.cluster_in, r.app_code_in};
					end else begin
						dir_first[slot] = {r.cluster_in, r.app_code_in};
					end
				end
			end
			MODE_PUB: begin
				if (r.publisher_sector > ((dir_ver == VERSION_2) ? LIMIT_V2 : LIMIT_V1)) begin
					st = STATUS_PUB_RANGE;
				end else begin
					pub_code = r.publisher_sector[5:0];
				end
			end
			MODE_CRC: begin
				o.crc_value = region_crc(r.region);
				o.crc_match = (o.crc_value == r.expected_crc);
			end
		endcase
		o.status = st;
		return o;
	endfunction

	// mostly well-formed sectors and publisher values, some noise over the full range
	function automatic req_t random_request();
		req_t r;
		int roll;
		r.cluster_in = 8'($urandom_range(0, 255));
		r.app_code_in = 8'($urandom_range(0, 255));
		r.region = 1'($urandom_range(0, 1));
		r.expected_crc = 8'($urandom_range(0, 255));
		roll = $urandom_range(0, 99);
		if (roll < 30) r.mode = MODE_READ;
		else if (roll < 60) r.mode = MODE_WRITE;
		else if (roll < 75) r.mode = MODE_PUB;
		else r.mode = MODE_CRC;
		roll = $urandom_range(0, 99);
		if (roll < 45) begin
			r.sector = 8'($urandom_range(1, FIRST_ENTRIES));
		end else if (roll < 85) begin
			r.sector = 8'($urandom_range(SPLIT_SECTOR + 1, SPLIT_SECTOR + SECOND_ENTRIES));
		end else begin
			r.sector = 8'($urandom_range(0, 255));
		end
		if ($urandom_range(0, 99) < 70) r.publisher_sector = 8'($urandom_range(0, 8'h30));
		else r.publisher_sector = 8'($urandom_range(0, 255));
		if (r.mode == MODE_CRC && $urandom_range(0, 1)) r.expected_crc = region_crc(r.region);
		return r;
	endfunction

	task automatic idle_len(inout int calm, output int len);
		int roll;
		roll = $urandom_range(0, 99);
		if (calm > 0) begin
			calm--;
			len = 0;
		end else if (roll < 4) begin
			calm = $urandom_range(20, 100);
			len = 0;
		end else if (roll < 55) begin
			len = 0;
		end else if (roll < 88) begin
			len = $urandom_range(1, 3);
		end else if (roll < 97) begin
			len = $urandom_range(4, 12);
		end else begin
			len = $urandom_range(20, 60);
		end
	endtask

	task automatic plan_add(input logic set_ver, input logic [1:0] ver, input logic [1:0] mode,
			input logic [7:0] sector, input logic [7:0] cl, input logic [7:0] app,
			input logic [7:0] pub, input logic region, input logic [7:0] crc, input logic typed,
			input logic [1:0] st);
		plan_row_t row;
		row.set_ver = set_ver;
		row.ver = ver;
		row.item.mode = mode;
		row.item.sector = sector;
		row.item.cluster_in = cl;
		row.item.app_code_in = app;
		row.item.publisher_sector = pub;
		row.item.region = region;
		row.item.expected_crc = crc;
		row.typed = typed;
		row.status = st;
		plan.push_back(row);
	endtask

	// version writes only with nothing in flight
	task automatic set_version(input logic [1:0] v);
		req_valid <= 1'b0;
		wait (outstanding == 0);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen <= 1'b0;
		if (v == VERSION_2 && dir_ver == VERSION_1) begin
			for (int i = 0; i < SECOND_ENTRIES; i++) dir_second[i] = '0;
		end
		dir_ver = v;
	endtask

	task automatic send_request(input req_t r, input logic typed, input logic [1:0] st);
		rsp_t want;
		int gap;
		want = directory_predict(r);
		if (typed) begin
			want = '0;
			want.status = st;
		end
		result_q.push_back(want);
		outstanding++;
		idle_len(send_calm, gap);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
	endtask

	task automatic compare_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
			errors++;
		end
	endtask

	initial begin : result_sink
		rsp_t want;
		int hold, taken, calm;
		hold = 0;
		taken = 0;
		calm = 0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid && rsp_ready) begin
				if (result_q.size() == 0) begin
					$display("%0t: unexpected transfer, actual %p", $time, rsp);
					errors++;
				end else begin
					want = result_q.pop_front();
					outstanding--;
					compare_field("status", 8'(want.status), 8'(rsp.status));
					compare_field("cluster_out", want.cluster_out, rsp.cluster_out);
					compare_field("app_code_out", want.app_code_out, rsp.app_code_out);
					compare_field("crc_value", want.crc_value, rsp.crc_value);
					compare_field("crc_match", 8'(want.crc_match), 8'(rsp.crc_match));
				end
				taken++;
				// long hold-off so the block backs up into its input
				if (taken == SQUEEZE_AT) hold = SQUEEZE_CYCLES;
				else idle_len(calm, hold);
			end else if (hold > 0) begin
				hold--;
			end else if ($urandom_range(0, 49) == 0) begin
				hold = $urandom_range(1, 6);
			end
			rsp_ready <= (hold == 0);
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
			else quiet++;
		end
		$display("%0t: no transfer for %0d cycles", $time, quiet);
		$display("CHECK FAILED");
		$finish;
	end

	initial begin : stimulus
		logic [1:0] phase_vers [$];
		for (int i = 0; i < FIRST_ENTRIES; i++) dir_first[i] = '0;
		for (int i = 0; i < SECOND_ENTRIES; i++) dir_second[i] = '0;
		pub_code = '0;
		dir_ver = VERSION_1;
		phase_vers = '{VERSION_2, VERSION_0, VERSION_2, VERSION_3, VERSION_1, VERSION_2,
			VERSION_1, VERSION_2};

		// version 1: sector map edges, writes, publisher limit, both crc regions
		plan_add(1'b1, VERSION_1, MODE_READ, 8'd1, 8'h5a, 8'hc3, 8'h00, 1'b0, 8'h00, 1'b1,
			STATUS_OK);
		plan_add(1'b0, VERSION_1, MODE_READ, 8'd15, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 1'b1,
			STATUS_OK);
		plan_add(1'b0, VERSION_1, MODE_READ, 8'd0, 8'hff, 8'hff, 8'hff, 1'b1, 8'hff, 1'b1,
			STATUS_BAD_SECTOR);
		plan_add(1'b0, VERSION_1, MODE_READ, 8'd16, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 1'b1,
			STATUS_BAD_SECTOR);
		plan_add(1'b0, VERSION_1, MODE_READ, 8'd17, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 1'b1,
			STATUS_NEED_V2);
		plan_add(1'b0, VERSION_1, MODE_READ, 8'd39, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 1'b1,
			STATUS_NEED_V2);
		plan_add(1'b0, VERSION_1, MODE_READ, 8'd40, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 1'b1,
			STATUS_BAD_SECTOR);
		plan_add(1'b0, VERSION_1, MODE_READ, 8'd255, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 1'b1,
			STATUS_BAD_SECTOR);
		plan_add(1'b0, VERSION_1, MODE_WRITE, 8'd1, 8'hff, 8'hff, 8'h00, 1'b0, 8'h00, 1'b1,
			STATUS_OK);
		plan_add(1'b0, VERSION_1, MODE_WRITE, 8'd15, 8'h00, 8'ha5, 8'h00, 1'b0, 8'h00, 1'b1,
			STATUS_OK);
		plan_add(1'b0, VERSION_1, MODE_WRITE, 8'd39, 8'h12, 8'h34, 8'h00, 1'b0, 8'h00, 1'b1,
			STATUS_NEED_V2);
		plan_add(1'b0, VERSION_1, MODE_READ, 8'd1, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0,
			STATUS_OK);
		plan_add(1'b0, VERSION_1, MODE_PUB, 8'd0, 8'h00, 8'h00, 8'h0f, 1'b0, 8'h00, 1'b1,
			STATUS_OK);
		plan_add(1'b0, VERSION_1, MODE_PUB, 8'd0, 8'h00, 8'h00, 8'h10, 1'b0, 8'h00, 1'b1,
			STATUS_PUB_RANGE);
		plan_add(1'b0, VERSION_1, MODE_PUB, 8'd0, 8'h00, 8'h00, 8'hff, 1'b0, 8'h00, 1'b1,
			STATUS_PUB_RANGE);
		plan_add(1'b0, VERSION_1, MODE_CRC, 8'd0, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0,
			STATUS_OK);
		plan_add(1'b0, VERSION_1, MODE_CRC, 8'd0, 8'h00, 8'h00, 8'h00, 1'b1, 8'hff, 1'b0,
			STATUS_OK);
		// version 2: second table, the wider publisher limit and both crc regions; then back to version 1
		plan_add(1'b1, VERSION_2, MODE_WRITE, 8'd17, 8'hff, 8'h01, 8'h00, 1'b0, 8'h00, 1'b1,
			STATUS_OK);
		plan_add(1'b0, VERSION_2, MODE_WRITE, 8'd39, 8'h80, 8'hff, 8'h00, 1'b0, 8'h00, 1'b1,
			STATUS_OK);
		plan_add(1'b0, VERSION_2, MODE_READ, 8'd39, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0,
			STATUS_OK);
		plan_add(1'b0, VERSION_2, MODE_PUB, 8'd0, 8'h00, 8'h00, 8'h27, 1'b0, 8'h00, 1'b1,
			STATUS_OK);
		plan_add(1'b0, VERSION_2, MODE_PUB, 8'd0, 8'h00, 8'h00, 8'h28, 1'b0, 8'h00, 1'b1,
			STATUS_PUB_RANGE);
		plan_add(1'b0, VERSION_2, MODE_CRC, 8'd0, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00, 1'b0,
			STATUS_OK);
		plan_add(1'b0, VERSION_2, MODE_CRC, 8'd0, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0,
			STATUS_OK);
		plan_add(1'b1, VERSION_1, MODE_READ, 8'd17, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 1'b1,
			STATUS_NEED_V2);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[k]) begin
			if (plan[k].set_ver) set_version(plan[k].ver);
			send_request(plan[k].item, plan[k].typed, plan[k].status);
		end

		foreach (phase_vers[p]) begin
			set_version(phase_vers[p]);
			repeat (PHASE_ITEMS) send_request(random_request(), 1'b0, STATUS_OK);
		end

		req_valid <= 1'b0;
		wait (outstanding == 0);
		repeat (60) @(posedge clk);
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
